[rtl/core/ubdc_pkg.sv]
// Package for the UART baud divider calculator: field widths, reset values
// and the fraction-to-modulation table. Depends on nothing.
package ubdc_pkg;

    // Field widths.
    localparam int CLK_W   = 26;
    localparam int BAUD_W  = 22;
    localparam int PRE_W   = 16;
    localparam int FMOD_W  = 4;
    localparam int SMOD_W  = 8;

    // Divider datapath widths: the partial remainder needs one bit over the divisor.
    localparam int REM_W   = BAUD_W + 1;
    // The fraction is below 100, so seven quotient bits cover it.
    localparam int FRAC_W  = 7;
    // Remainder times 100 fits in this many bits.
    localparam int SCALE_W = BAUD_W + FRAC_W;

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(3000000);
    localparam logic [CLK_W-1:0] OS_LIMIT    = CLK_W'(16);

    // Fraction table: upper bounds of each step, last step open.
    localparam int NSTEPS = 36;

    localparam logic [FRAC_W-1:0] FRAC_LIMIT [NSTEPS-1] = '{
        7'd5,  7'd7,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd21, 7'd22,
        7'd25, 7'd30, 7'd33, 7'd35, 7'd37, 7'd40, 7'd42, 7'd43, 7'd50,
        7'd57, 7'd60, 7'd62, 7'd64, 7'd66, 7'd70, 7'd71, 7'd75, 7'd78,
        7'd80, 7'd83, 7'd84, 7'd85, 7'd87, 7'd90, 7'd91, 7'd92
    };

    localparam logic [SMOD_W-1:0] FRAC_BYTE [NSTEPS] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h11, 8'h21,
        8'h22, 8'h44, 8'h25, 8'h49, 8'h4A, 8'h52, 8'h92, 8'h53, 8'h55,
        8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6, 8'hB7, 8'hBB, 8'hDD,
        8'hED, 8'hEE, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
    };

    // Second modulation byte for a two-digit fraction: first step whose bound holds.
    function automatic logic [SMOD_W-1:0] second_mod_of(input logic [FRAC_W-1:0] frac);
        logic [SMOD_W-1:0] res;
        res = FRAC_BYTE[NSTEPS-1];
        for (int i = NSTEPS - 2; i >= 0; i--) begin
            if (frac <= FRAC_LIMIT[i]) begin
                res = FRAC_BYTE[i];
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/ubdc_baud_if.sv]
// Request channel of the UART baud divider calculator: one baud rate per beat.
// Depends on ubdc_pkg for the field width.
interface ubdc_baud_if import ubdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud;

    modport source (output valid, output baud, input ready);
    modport sink   (input valid, input baud, output ready);
endinterface

[rtl/core/ubdc_result_if.sv]
// Result channel of the UART baud divider calculator: divider settings per beat.
// Depends on ubdc_pkg for the field widths.
interface ubdc_result_if import ubdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              oversample;
    logic [PRE_W-1:0]  prescale;
    logic [FMOD_W-1:0] first_mod;
    logic [SMOD_W-1:0] second_mod;
    logic              rate_error;

    modport source (output valid, output oversample, output prescale, output first_mod,
                    output second_mod, output rate_error, input ready);
    modport sink   (input valid, input oversample, input prescale, input first_mod,
                    input second_mod, input rate_error, output ready);
endinterface

[rtl/core/ubdc_cfg_if.sv]
// Configuration write channel: one source clock frequency per beat.
// Depends on ubdc_pkg for the register width.
interface ubdc_cfg_if import ubdc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ubdc_div_cell.sv]
// One restoring-division cell: produces one quotient bit per beat and hands
// the partial remainder, divisor and side data to the next cell. Uses ubdc_pkg.
module ubdc_div_cell import ubdc_pkg::*; #(
    parameter int WW = 26,
    parameter int WS = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [WW-1:0]     i_work,
    input  logic [BAUD_W-1:0] i_div,
    input  logic [WS-1:0]     i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [WW-1:0]     o_work,
    output logic [BAUD_W-1:0] o_div,
    output logic [WS-1:0]     o_side
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [WW-1:0]     r_work;
    logic [BAUD_W-1:0] r_div;
    logic [WS-1:0]     r_side;

    logic [REM_W-1:0]  shifted;
    logic [REM_W:0]    trial;
    logic              qbit;
    logic [REM_W-1:0]  n_rem;
    logic [WW-1:0]     n_work;

    // Bring down the next dividend bit and try subtracting the divisor.
    always_comb begin
        shifted = {i_rem[REM_W-2:0], i_work[WW-1]};
        trial   = {1'b0, shifted} - {2'b00, i_div};
        qbit    = ~trial[REM_W];
        n_rem   = qbit ? trial[REM_W-1:0] : shifted;
        n_work  = {i_work[WW-2:0], qbit};
    end

    // Valid bit under reset; payload just follows the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_work <= n_work;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_work  = r_work;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

[rtl/core/ubdc_div_chain.sv]
// Row of WW division cells giving a WW-bit quotient and its remainder.
// Uses ubdc_pkg and ubdc_div_cell.
module ubdc_div_chain import ubdc_pkg::*; #(
    parameter int WW = 26,
    parameter int WS = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [WW-1:0]     i_dividend,
    input  logic [BAUD_W-1:0] i_div,
    input  logic [WS-1:0]     i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [WW-1:0]     o_quot,
    output logic [BAUD_W-1:0] o_div,
    output logic [WS-1:0]     o_side
);

    logic              link_valid [WW+1];
    logic [REM_W-1:0]  link_rem   [WW+1];
    logic [WW-1:0]     link_work  [WW+1];
    logic [BAUD_W-1:0] link_div   [WW+1];
    logic [WS-1:0]     link_side  [WW+1];

    assign link_valid[0] = i_valid;
    assign link_rem[0]   = i_rem;
    assign link_work[0]  = i_dividend;
    assign link_div[0]   = i_div;
    assign link_side[0]  = i_side;

    // Each cell shifts one dividend bit out and one quotient bit in.
    for (genvar g = 0; g < WW; g++) begin : g_cell
        ubdc_div_cell #(
            .WW (WW),
            .WS (WS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (link_valid[g]),
            .i_rem   (link_rem[g]),
            .i_work  (link_work[g]),
            .i_div   (link_div[g]),
            .i_side  (link_side[g]),
            .o_valid (link_valid[g+1]),
            .o_rem   (link_rem[g+1]),
            .o_work  (link_work[g+1]),
            .o_div   (link_div[g+1]),
            .o_side  (link_side[g+1])
        );
    end

    assign o_valid = link_valid[WW];
    assign o_rem   = link_rem[WW];
    assign o_quot  = link_work[WW];
    assign o_div   = link_div[WW];
    assign o_side  = link_side[WW];

endmodule

[rtl/core/uart_baud_divider_calc_core.sv]
// Top level of the UART baud divider calculator: divider cell rows, the
// fraction scaling stage and the output encoder. Uses ubdc_pkg, the channel
// interfaces and ubdc_div_chain.
//
// Each requested baud rate yields one set of baud generator settings. The
// block takes a new request every cycle unless a result is stalled at the
// output: a row of 26 division cells finds the whole ratio clock_hz / baud and
// its remainder, one stage scales the remainder by 100, a row of 7 more cells
// finds the two-digit fraction, and a final register encodes prescale,
// modulation and the error flag. The whole pipeline advances together and
// holds while a finished result waits to be taken. The clock frequency
// register is written through the configuration channel, which is always
// ready; it is sampled as a request enters, so it should change only while
// no request is in flight.
module uart_baud_divider_calc_core import ubdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ubdc_cfg_if.sink     i_cfg,
    ubdc_baud_if.sink    i_baud,
    ubdc_result_if.source o_res
);

    localparam int SIDE2_W = CLK_W + 1;

    logic [CLK_W-1:0] r_clk_hz;
    logic             en;

    // Configuration register; always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLOCK_RESET;
        end else if (i_cfg.valid) begin
            r_clk_hz <= i_cfg.data;
        end
    end

    // Global pipeline enable: move unless a result is stalled at the output.
    logic r_out_valid;
    assign en           = ~r_out_valid | o_res.ready;
    assign i_baud.ready = en;

    // Whole ratio: clock_hz / baud.
    logic              c1_valid;
    logic [REM_W-1:0]  c1_rem;
    logic [CLK_W-1:0]  c1_quot;
    logic [BAUD_W-1:0] c1_div;
    logic [0:0]        c1_zero;

    ubdc_div_chain #(
        .WW (CLK_W),
        .WS (1)
    ) u_whole (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_baud.valid),
        .i_rem      ('0),
        .i_dividend (r_clk_hz),
        .i_div      (i_baud.baud),
        .i_side     (i_baud.baud == '0),
        .o_valid    (c1_valid),
        .o_rem      (c1_rem),
        .o_quot     (c1_quot),
        .o_div      (c1_div),
        .o_side     (c1_zero)
    );

    // Scale the remainder by 100 with shifts and adds.
    logic               r_mid_valid;
    logic [SCALE_W-1:0] r_mid_scaled;
    logic [CLK_W-1:0]   r_mid_n;
    logic [BAUD_W-1:0]  r_mid_div;
    logic               r_mid_zero;
    logic [SCALE_W-1:0] rem_ext;
    logic [SCALE_W-1:0] n_mid_scaled;

    assign rem_ext      = SCALE_W'(c1_rem[BAUD_W-1:0]);
    assign n_mid_scaled = (rem_ext << 6) + (rem_ext << 5) + (rem_ext << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (en) begin
            r_mid_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_scaled <= n_mid_scaled;
            r_mid_n      <= c1_quot;
            r_mid_div    <= c1_div;
            r_mid_zero   <= c1_zero[0];
        end
    end

    // Fraction: (100 * remainder) / baud; the top bits already sit below the divisor.
    logic               c2_valid;
    logic [REM_W-1:0]   c2_rem;
    logic [FRAC_W-1:0]  c2_frac;
    logic [BAUD_W-1:0]  c2_div;
    logic [SIDE2_W-1:0] c2_side;

    ubdc_div_chain #(
        .WW (FRAC_W),
        .WS (SIDE2_W)
    ) u_frac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_mid_valid),
        .i_rem      (REM_W'(r_mid_scaled[SCALE_W-1:FRAC_W])),
        .i_dividend (r_mid_scaled[FRAC_W-1:0]),
        .i_div      (r_mid_div),
        .i_side     ({r_mid_zero, r_mid_n}),
        .o_valid    (c2_valid),
        .o_rem      (c2_rem),
        .o_quot     (c2_frac),
        .o_div      (c2_div),
        .o_side     (c2_side)
    );

    // Encode the divider settings from the whole ratio and the fraction.
    logic [CLK_W-1:0]   ratio;
    logic               zero_baud;
    logic [CLK_W-5:0]   ratio_hi;
    logic               n_os;
    logic [PRE_W-1:0]   n_pre;
    logic [FMOD_W-1:0]  n_fmod;
    logic [SMOD_W-1:0]  n_smod;
    logic               n_err;

    assign ratio     = c2_side[CLK_W-1:0];
    assign zero_baud = c2_side[CLK_W];
    assign ratio_hi  = ratio[CLK_W-1:4];

    always_comb begin
        if (ratio <= OS_LIMIT) begin
            n_os   = 1'b0;
            n_pre  = PRE_W'(ratio[4:0]);
            n_fmod = '0;
        end else begin
            n_os   = 1'b1;
            n_fmod = ratio[3:0];
            if (ratio_hi[CLK_W-5:PRE_W] != '0) begin
                n_pre = '1;
            end else begin
                n_pre = ratio_hi[PRE_W-1:0];
            end
        end
        n_smod = second_mod_of(c2_frac);
        n_err  = (n_pre == '0);
        if (zero_baud) begin
            n_os   = 1'b0;
            n_pre  = '0;
            n_fmod = '0;
            n_smod = '0;
            n_err  = 1'b1;
        end
    end

    // Output register.
    logic              r_os;
    logic [PRE_W-1:0]  r_pre;
    logic [FMOD_W-1:0] r_fmod;
    logic [SMOD_W-1:0] r_smod;
    logic              r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_os   <= n_os;
            r_pre  <= n_pre;
            r_fmod <= n_fmod;
            r_smod <= n_smod;
            r_err  <= n_err;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.oversample = r_os;
    assign o_res.prescale   = r_pre;
    assign o_res.first_mod  = r_fmod;
    assign o_res.second_mod = r_smod;
    assign o_res.rate_error = r_err;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for uart_baud_divider_calc_core: drives baud rate requests
// and clock settings, predicts divider settings and checks every result beat.
// Depends on ubdc_pkg, the three channel interfaces and the core RTL.
module testbench;
    import ubdc_pkg::*;

    // Run control.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int MAX_REPORTS     = 10;

    // Fraction steps: inclusive upper bound of each step, then the pattern byte of each step.
    localparam logic [6:0] STEP_TOP [35] = '{
        7'd5,  7'd7,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd21, 7'd22,
        7'd25, 7'd30, 7'd33, 7'd35, 7'd37, 7'd40, 7'd42, 7'd43, 7'd50,
        7'd57, 7'd60, 7'd62, 7'd64, 7'd66, 7'd70, 7'd71, 7'd75, 7'd78,
        7'd80, 7'd83, 7'd84, 7'd85, 7'd87, 7'd90, 7'd91, 7'd92
    };
    localparam logic [7:0] STEP_PATTERN [36] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h11, 8'h21,
        8'h22, 8'h44, 8'h25, 8'h49, 8'h4A, 8'h52, 8'h92, 8'h53, 8'h55,
        8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6, 8'hB7, 8'hBB, 8'hDD,
        8'hED, 8'hEE, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
    };

    localparam int STD_RATES [12] = '{
        300, 1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200, 230400, 460800, 921600
    };

    typedef struct packed {
        logic              oversample;
        logic [PRE_W-1:0]  prescale;
        logic [FMOD_W-1:0] first_mod;
        logic [SMOD_W-1:0] second_mod;
        logic              rate_error;
    } t_baud_settings;

    // Holds the settings expected for requests in flight and checks result beats.
    class divisor_board;
        logic [CLK_W-1:0] clock_hz;
        t_baud_settings   expected_settings [$];
        int               failures;
        int               reports;

        function new();
            clock_hz  = CLOCK_RESET;
            failures  = 0;
            reports   = 0;
        endfunction

        function void set_clock(logic [CLK_W-1:0] value);
            clock_hz = value;
        endfunction

        function int pending();
            return expected_settings.size();
        endfunction

        // Pattern byte of the first fraction step whose bound holds.
        function logic [SMOD_W-1:0] fraction_pattern(longint unsigned frac);
            for (int i = 0; i < 35; i++) begin
                if (frac <= STEP_TOP[i]) begin
                    return STEP_PATTERN[i];
                end
            end
            return STEP_PATTERN[35];
        endfunction

        function t_baud_settings predict_settings(logic [BAUD_W-1:0] baud);
            t_baud_settings  res;
            longint unsigned scaled;
            longint unsigned whole;
            longint unsigned pre;
            res = '0;
            // A zero rate has no defined ratio and is flagged as an error.
            if (baud == 0) begin
                res.rate_error = 1'b1;
                return res;
            end
            scaled = (longint'(clock_hz) * 100) / longint'(baud);
            whole  = scaled / 100;
            if (whole <= 16) begin
                pre = whole;
            end else begin
                res.oversample = 1'b1;
                res.first_mod  = whole[3:0];
                pre = whole >> 4;
                // The prescaler saturates when the ratio is too large.
                if (pre > 64'hFFFF) begin
                    pre = 64'hFFFF;
                end
            end
            res.prescale   = pre[PRE_W-1:0];
            res.second_mod = fraction_pattern(scaled % 100);
            res.rate_error = (pre == 0);
            return res;
        endfunction

        function void note_baud(logic [BAUD_W-1:0] baud);
            expected_settings.push_back(predict_settings(baud));
        endfunction

        function void check_result(t_baud_settings got);
            t_baud_settings exp_set;
            if (expected_settings.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected result beat: os=%0d pre=%0d fm=%0d sm=%h err=%0d",
                             got.oversample, got.prescale, got.first_mod,
                             got.second_mod, got.rate_error);
                end
                return;
            end
            exp_set = expected_settings.pop_front();
            if (got !== exp_set) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("mismatch at %0t: expected os=%0d pre=%0d fm=%0d sm=%h err=%0d",
                             $realtime, exp_set.oversample, exp_set.prescale,
                             exp_set.first_mod, exp_set.second_mod, exp_set.rate_error);
                    $display("                 actual   os=%0d pre=%0d fm=%0d sm=%h err=%0d",
                             got.oversample, got.prescale, got.first_mod,
                             got.second_mod, got.rate_error);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ubdc_cfg_if    cfg_ch ();
    ubdc_baud_if   baud_ch ();
    ubdc_result_if res_ch ();

    divisor_board sb;
    bit           hold_req;
    bit           steady;
    int           quiet_cycles;

    uart_baud_divider_calc_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_baud  (baud_ch),
        .o_res   (res_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Idle stretch length: mostly none or short, a few long.
    function automatic int idle_span();
        int pick;
        if (steady) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    // Random baud rate, weighted toward realistic rates and the mode boundaries.
    function automatic logic [BAUD_W-1:0] pick_baud(logic [CLK_W-1:0] clk_hz);
        longint unsigned near;
        int              pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: begin
                return BAUD_W'($urandom_range(300, 3000000));
            end
            4: begin
                return BAUD_W'(STD_RATES[$urandom_range(0, 11)]);
            end
            5: begin
                return BAUD_W'($urandom());
            end
            6: begin
                return BAUD_W'($urandom_range(1, 255));
            end
            7, 8: begin
                // Around the switch between direct and oversampled division.
                near = longint'(clk_hz) / $urandom_range(15, 18) + $urandom_range(0, 4);
                near = (near > 2) ? near - 2 : near;
                return BAUD_W'(near);
            end
            default: begin
                return BAUD_W'($urandom_range(0, 15));
            end
        endcase
    endfunction

    // Offer one request beat and wait until it is taken.
    task automatic send_baud(logic [BAUD_W-1:0] baud);
        baud_ch.valid <= 1'b1;
        baud_ch.baud  <= baud;
        do @(posedge i_clk); while (baud_ch.ready !== 1'b1);
        sb.note_baud(baud);
    endtask

    // Send one request and then an idle stretch; the last one of a run drops valid.
    task automatic send_with_gap(logic [BAUD_W-1:0] baud, bit last);
        int gap;
        send_baud(baud);
        gap = idle_span();
        if (gap > 0 || last) begin
            baud_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every expected result has come back.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the clock frequency register; only called while nothing is in flight.
    task automatic write_clock(logic [CLK_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_clock(value);
        @(posedge i_clk);
    endtask

    task automatic random_phase(logic [CLK_W-1:0] clk_hz, int count);
        drain();
        write_clock(clk_hz);
        for (int i = 0; i < count; i++) begin
            send_with_gap(pick_baud(clk_hz), i == count - 1);
        end
    endtask

    // Result side: check each beat and pace ready.
    initial begin
        t_baud_settings got;
        int             hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if ((res_ch.valid & res_ch.ready) === 1'b1) begin
                got.oversample = res_ch.oversample;
                got.prescale   = res_ch.prescale;
                got.first_mod  = res_ch.first_mod;
                got.second_mod = res_ch.second_mod;
                got.rate_error = res_ch.rate_error;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (steady) begin
                res_ch.ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 80) begin
                res_ch.ready <= 1'b1;
            end else begin
                hold_left = idle_span();
                res_ch.ready <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (baud_ch.valid & baud_ch.ready) === 1'b1 ||
            (res_ch.valid & res_ch.ready) === 1'b1 ||
            (cfg_ch.valid & cfg_ch.ready) === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed requests, then random phases over several clocks.
    initial begin
        logic [BAUD_W-1:0] directed [$];
        sb           = new();
        hold_req     = 1'b0;
        steady       = 1'b0;
        quiet_cycles = 0;
        i_rst_n       <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        baud_ch.valid <= 1'b0;
        baud_ch.baud  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset clock: zero rate, field extremes, the mode
        // boundary, rates above the clock and prescale saturation.
        directed = '{
            22'd0, 22'd1, 22'h3FFFFF, 22'h200000, 22'd300, 22'd3000000, 22'd3000001,
            22'd187500, 22'd176470, 22'd176471, 22'd115200, 22'd9600, 22'd57600,
            22'd2999999, 22'd1500000, 22'd45, 22'd2, 22'd7, 22'd16, 22'd255,
            22'd1000, 22'h155555, 22'h2AAAAA
        };
        foreach (directed[i]) begin
            send_with_gap(directed[i], i == directed.size() - 1);
        end

        // Highest rated clock, with one long hold-off on the result side.
        drain();
        write_clock(CLK_W'(48000000));
        hold_req = 1'b1;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_with_gap(pick_baud(CLK_W'(48000000)), i == ITEMS_PER_PHASE - 1);
        end

        // Largest register value, first half of it without idling on either side.
        drain();
        write_clock({CLK_W{1'b1}});
        steady = 1'b1;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) begin
                steady = 1'b0;
            end
            send_with_gap(pick_baud({CLK_W{1'b1}}), i == ITEMS_PER_PHASE - 1);
        end

        random_phase(CLK_W'(0), 30);
        random_phase(CLK_W'(1), 30);
        random_phase(CLK_W'(16000000), ITEMS_PER_PHASE);
        random_phase(CLK_W'(1843200), ITEMS_PER_PHASE);
        random_phase(CLK_W'($urandom_range(1, 48000000)), ITEMS_PER_PHASE);
        random_phase(CLK_W'($urandom()), ITEMS_PER_PHASE);
        random_phase(CLK_W'($urandom_range(1000, 2000000)), ITEMS_PER_PHASE);
        random_phase(CLK_W'(12000000), ITEMS_PER_PHASE);
        random_phase(CLOCK_RESET, ITEMS_PER_PHASE);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
